// ===== rtl/bmp24_pkg.sv =====
`default_nettype none
package bmp24_pkg;

  localparam int unsigned ByteCountBitsDefault = 32;
  localparam int unsigned HdrLen = 54;
  localparam logic [15:0] MaxSideReset = 16'd32768;
  localparam logic [30:0] MaxPixReset = 31'd67108864;

  // register byte addresses
  localparam logic [2:0] AddrMaxSide = 3'd0;
  localparam logic [2:0] AddrMaxPix  = 3'd4;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC     = 3'd0,
    ERR_VARIANT   = 3'd1,
    ERR_DIMENSION = 3'd2,
    ERR_OFFSET    = 3'd3,
    ERR_DECLARED  = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHECK  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_TRAIL  = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_e;

  // byte beat as classified by the front part
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } beat_t;

  // one result item; 2+32+15+15+16+16+3+1 = 100 bits
  typedef struct packed {
    logic        last;
    logic [2:0]  error_code;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [14:0] row;
    logic [14:0] column;
    logic [31:0] pixel_rgba;
    logic [1:0]  kind;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned TdataBits = 104;

endpackage
`default_nettype wire

// ===== rtl/bmp24_stream_decoder.sv =====
`default_nettype none
// Streaming decoder for 24 bpp BMP files. One file byte is taken per beat on the
// slave side (tdata = data byte, tlast = end of file). A small input queue decouples
// the byte stream from the decode core; the core takes one byte a cycle except while
// it runs the header checks and their multiplies after the 54th header byte, and
// except while results are waiting: one waiting result stalls only when the master
// side does not take it in that cycle, and two results of one beat always stall input.
// Results leave on the master side: tuser = kind, tlast = last of the beat,
// tdata = pixel, column, row, width, height, error code from bit 0 up.
module bmp24_stream_decoder
  import bmp24_pkg::*;
#(
  parameter int unsigned ByteCountBits = ByteCountBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // data_byte
  input  wire logic         s_axis_tlast,  // end_of_file
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pixel_rgba[31:0], column[46:32], row[61:47], image_width[77:62],
  // image_height[93:78], error_code[96:94], zero fill
  output logic [TdataBits-1:0] m_axis_tdata,
  output logic [1:0]        m_axis_tuser,  // kind
  output logic              m_axis_tlast   // last
);
  logic [15:0] max_side_q;
  logic [30:0] max_pix_q;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_side_q <= MaxSideReset;
      max_pix_q <= MaxPixReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrMaxSide) max_side_q <= pwdata[15:0];
      if (paddr == AddrMaxPix) max_pix_q <= pwdata[30:0];
    end
  end
  always_comb begin
    case (paddr)
      AddrMaxSide: prdata = {16'd0, max_side_q};
      AddrMaxPix:  prdata = {1'b0, max_pix_q};
      default:     prdata = '0;
    endcase
  end

  // front queue
  beat_t q_in, q_out;
  logic q_valid, q_ready;
  assign q_in = '{data: s_axis_tdata, eof: s_axis_tlast};
  bmp24_fifo #(.Width($bits(beat_t)), .Depth(4)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(q_in),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_out)
  );

  result_t res;
  bmp24_core #(.ByteCountBits(ByteCountBits)) u_core (
    .clk_i, .rst_ni,
    .max_side_i(max_side_q), .max_pix_i(max_pix_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_beat_i(q_out),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {7'd0, res.error_code, res.image_height, res.image_width,
                         res.row, res.column, res.pixel_rgba};
endmodule
`default_nettype wire

// ===== rtl/bmp24_fifo.sv =====
`default_nettype none
module bmp24_fifo
  import bmp24_pkg::*;
#(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [Width-1:0] out_data_o
);
  localparam int unsigned Aw = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != Depth[Aw:0]);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth[Aw:0]) else $error("fifo count overflow");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == Depth[Aw:0]) |-> !push) else $error("push while full");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop while empty");
endmodule
`default_nettype wire

// ===== rtl/bmp24_core.sv =====
`default_nettype none
// back part: header capture and checks, skip, pixel assembly, end of file
module bmp24_core
  import bmp24_pkg::*;
#(
  parameter int unsigned ByteCountBits = ByteCountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] max_side_i,
  input  wire logic [30:0] max_pix_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire beat_t       in_beat_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output result_t          out_res_o
);
  localparam int unsigned Cb = ByteCountBits;
  localparam logic [Cb-1:0] CountMax = '1;

  phase_e ph_q, ph_d;
  logic [Cb-1:0] cnt_q, cnt_d;
  logic [7:0] hdr_q [HdrLen];
  logic bu_q, bu_d;
  logic [15:0] col_q, col_d, rowc_q, rowc_d;
  logic [1:0] tp_q, tp_d, pad_q, pad_d;
  logic [15:0] bg_q, bg_d;

  // decoded header fields, registered once the header is in
  logic [31:0] off_q, decl_q;
  logic [15:0] w_q, h_q;

  // check pipeline
  logic [2:0] chk_st_q;
  logic [2:0] code_q;
  logic code_set_q;
  logic [47:0] prod_q;
  logic [47:0] dsz_q;
  logic eof_pend_q;

  // two result slots (pending results of one beat)
  result_t r0_q, r1_q;
  logic [1:0] nres_q;

  function automatic logic [31:0] le32(input logic [7:0] b0, b1, b2, b3);
    le32 = {b3, b2, b1, b0};
  endfunction

  logic [31:0] hw, hh, habs, hoff, hdecl;
  assign hw    = le32(hdr_q[18], hdr_q[19], hdr_q[20], hdr_q[21]);
  assign hh    = le32(hdr_q[22], hdr_q[23], hdr_q[24], hdr_q[25]);
  assign habs  = hh[31] ? (32'd0 - hh) : hh;
  assign hoff  = le32(hdr_q[10], hdr_q[11], hdr_q[12], hdr_q[13]);
  assign hdecl = le32(hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5]);

  // a single waiting result does not block a beat when it leaves this cycle
  logic busy;
  assign busy = (ph_q == PH_CHECK) || (nres_q == 2'd2) ||
                (nres_q == 2'd1 && !out_ready_i);
  assign in_ready_o = !busy;
  assign out_valid_o = (nres_q != 2'd0);
  assign out_res_o = r0_q;

  logic take;
  assign take = in_valid_i && in_ready_o;

  logic [Cb-1:0] cnt_inc;
  assign cnt_inc = (cnt_q != CountMax) ? cnt_q + 1'b1 : cnt_q;

  result_t pix_r, ev_r;
  logic pix_emit;
  logic [15:0] dst;
  logic [15:0] rown;
  logic eof_ev;

  // per-beat work
  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; bu_d = bu_q; col_d = col_q; rowc_d = rowc_q;
    tp_d = tp_q; pad_d = pad_q; bg_d = bg_q;
    pix_r = '0; ev_r = '0; pix_emit = 1'b0; eof_ev = 1'b0;
    dst = bu_q ? (h_q - 16'd1 - rowc_q) : rowc_q;
    rown = rowc_q + 16'd1;
    if (take) begin
      cnt_d = cnt_inc;
      case (ph_q)
        PH_HEADER: begin
          if (cnt_inc == Cb'(HdrLen)) ph_d = PH_CHECK;
        end
        PH_SKIP: begin
          if ({{(32 > Cb ? 32 - Cb : 1){1'b0}}, cnt_inc} >= off_q) ph_d = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (pad_q != 2'd0) begin
            pad_d = pad_q - 2'd1;
            if (pad_q == 2'd1) begin
              rowc_d = rown;
              if (rown >= h_q) ph_d = PH_TRAIL;
            end
          end else if (tp_q == 2'd1) begin
            bg_d = {in_beat_i.data, bg_q[7:0]};
            tp_d = 2'd2;
          end else if (tp_q != 2'd2) begin
            bg_d = {8'd0, in_beat_i.data};
            tp_d = 2'd1;
          end else begin
            pix_emit = 1'b1;
            pix_r.kind = KIND_PIXEL;
            pix_r.pixel_rgba = {in_beat_i.data, bg_q[15:8], bg_q[7:0], 8'hFF};
            pix_r.column = col_q[14:0];
            pix_r.row = dst[14:0];
            tp_d = 2'd0;
            col_d = col_q + 16'd1;
            if (col_d >= w_q) begin
              col_d = '0;
              pad_d = w_q[1:0];
              if (w_q[1:0] == 2'd0) begin
                rowc_d = rown;
                if (rown >= h_q) ph_d = PH_TRAIL;
              end
            end
          end
        end
        default: ;
      endcase
      if (in_beat_i.eof && ph_d != PH_CHECK) begin
        if (ph_d == PH_TRAIL) begin
          eof_ev = 1'b1;
          ev_r.kind = ((decl_q == 32'd0) ||
            ({{(32 > Cb ? 32 - Cb : 1){1'b0}}, cnt_inc} >= decl_q)) ? KIND_DONE : KIND_ERROR;
          if (ev_r.kind == KIND_ERROR) ev_r.error_code = ERR_TRUNCATED;
        end else if (ph_d != PH_DRAIN) begin
          eof_ev = 1'b1;
          ev_r.kind = KIND_ERROR;
          ev_r.error_code = ERR_TRUNCATED;
        end
        ph_d = PH_HEADER; cnt_d = '0; bu_d = 1'b1; col_d = '0; rowc_d = '0;
        tp_d = '0; bg_d = '0; pad_d = '0;
      end
    end
  end

  // header capture
  always_ff @(posedge clk_i) begin
    if (take && ph_q == PH_HEADER && cnt_q < Cb'(HdrLen))
      hdr_q[cnt_q[5:0]] <= in_beat_i.data;
  end

  // main state and result slots; header checks run as a sequence of steps in PH_CHECK
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEADER; cnt_q <= '0; bu_q <= 1'b1; col_q <= '0; rowc_q <= '0;
      tp_q <= '0; pad_q <= '0; bg_q <= '0; nres_q <= '0;
      chk_st_q <= '0; code_set_q <= 1'b0; eof_pend_q <= 1'b0;
      off_q <= '0; decl_q <= '0; w_q <= '0; h_q <= '0;
      code_q <= '0; prod_q <= '0; dsz_q <= '0;
      r0_q <= '0; r1_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i && !(take && (pix_emit || eof_ev))) begin
        r0_q <= r1_q;
        nres_q <= nres_q - 2'd1;
      end
      if (ph_q == PH_CHECK) begin
        chk_st_q <= chk_st_q + 3'd1;
        case (chk_st_q)
          3'd0: begin
            off_q <= hoff; decl_q <= hdecl;
            w_q <= hw[15:0]; h_q <= habs[15:0];
            bu_q <= !hh[31];
            code_set_q <= 1'b1;
            if (hdr_q[0] != 8'h42 || hdr_q[1] != 8'h4D) code_q <= ERR_MAGIC;
            else if (le32(hdr_q[14], hdr_q[15], hdr_q[16], hdr_q[17]) != 32'd40 ||
                     {hdr_q[29], hdr_q[28]} != 16'd24 ||
                     le32(hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]) != 32'd0)
              code_q <= ERR_VARIANT;
            else if (hh == 32'h8000_0000 || hw[31] || hw == 32'd0 || habs == 32'd0 ||
                     hw > {16'd0, max_side_i} || habs > {16'd0, max_side_i})
              code_q <= ERR_DIMENSION;
            else code_set_q <= 1'b0;
          end
          3'd1: begin
            prod_q <= {16'd0, w_q} * {16'd0, h_q};
            dsz_q <= {30'd0, ({2'd0, w_q} * 18'd3 + 18'd3) & ~18'd3};
          end
          3'd2: begin
            dsz_q <= dsz_q[17:0] * {14'd0, h_q};
            if (!code_set_q && prod_q > {17'd0, max_pix_i}) begin
              code_q <= ERR_DIMENSION; code_set_q <= 1'b1;
            end
          end
          3'd3: begin
            if (!code_set_q && (off_q < 32'(HdrLen) ||
                ({16'd0, off_q} > {{(48 - Cb){1'b0}}, CountMax}))) begin
              code_q <= ERR_OFFSET; code_set_q <= 1'b1;
            end
          end
          default: begin
            chk_st_q <= '0;
            if (!code_set_q && decl_q != 32'd0 && (off_q > decl_q ||
                dsz_q > {16'd0, decl_q - off_q} ||
                ({16'd0, decl_q} > {{(48 - Cb){1'b0}}, CountMax}))) begin
              code_q <= ERR_DECLARED; code_set_q <= 1'b1;
            end
            // emit header outcome
            r0_q <= '0;
            r1_q <= '0;
            nres_q <= 2'd1;
            if (code_set_q || (decl_q != 32'd0 && (off_q > decl_q ||
                dsz_q > {16'd0, decl_q - off_q} ||
                ({16'd0, decl_q} > {{(48 - Cb){1'b0}}, CountMax})))) begin
              r0_q.kind <= KIND_ERROR;
              r0_q.error_code <= code_set_q ? code_q : ERR_DECLARED;
              r0_q.last <= 1'b1;
              ph_q <= PH_DRAIN;
              if (eof_pend_q) begin
                ph_q <= PH_HEADER; cnt_q <= '0; bu_q <= 1'b1;
              end
            end else begin
              r0_q.kind <= KIND_HEADER;
              r0_q.image_width <= w_q;
              r0_q.image_height <= bu_q ? hh[15:0] : h_q;
              if (eof_pend_q) begin
                r0_q.last <= 1'b0;
                r1_q.kind <= KIND_ERROR;
                r1_q.error_code <= ERR_TRUNCATED;
                r1_q.last <= 1'b1;
                nres_q <= 2'd2;
                ph_q <= PH_HEADER; cnt_q <= '0; bu_q <= 1'b1;
              end else begin
                r0_q.last <= 1'b1;
                ph_q <= (off_q == 32'(HdrLen)) ? PH_PIXELS : PH_SKIP;
              end
            end
          end
        endcase
      end else if (take) begin
        ph_q <= ph_d; cnt_q <= cnt_d; bu_q <= bu_d; col_q <= col_d;
        rowc_q <= rowc_d; tp_q <= tp_d; pad_q <= pad_d; bg_q <= bg_d;
        eof_pend_q <= (ph_d == PH_CHECK) && in_beat_i.eof;
        if (pix_emit && eof_ev) begin
          r0_q <= pix_r; r1_q <= ev_r; r1_q.last <= 1'b1; nres_q <= 2'd2;
        end else if (pix_emit) begin
          r0_q <= pix_r; r0_q.last <= 1'b1; nres_q <= 2'd1;
        end else if (eof_ev) begin
          r0_q <= ev_r; r0_q.last <= 1'b1; nres_q <= 2'd1;
        end
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_CHECK) |-> !take) else $error("beat taken during check");
  a_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= 2'd2) else $error("result slot overflow");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nres_q == 2'd1) |-> r0_q.last) else $error("final result without last");
endmodule
`default_nettype wire
